>>> design/dispersion_index_evaluator_macros.svh
// Assertion helpers for the dispersion index evaluator.
`ifndef DISPERSION_INDEX_EVALUATOR_MACROS_SVH
`define DISPERSION_INDEX_EVALUATOR_MACROS_SVH

// Implication in the same cycle, or with a sequence delay given in the consequent.
`define DIE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);

// Implication into the next cycle.
`define DIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/die_pkg.sv
package die_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NEG_SUM = 2'd1,
    ST_ZERO_WL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_FPH   = 3'd0,
    REG_TERMS = 3'd1,
    REG_C0    = 3'd2,
    REG_C1    = 3'd3,
    REG_C2    = 3'd4,
    REG_C3    = 3'd5,
    REG_C4    = 3'd6,
    REG_C5    = 3'd7
  } cfg_reg_t;

  // Four 32x32 partial products: lo*lo, lo*hi, hi*lo, hi*hi.
  typedef logic [3:0][63:0] part_t;

  localparam int NUM_COEFFS = 6;
  localparam int WL_W       = 24;
  localparam int FPH_SPAN   = 8;
  localparam int SQ_STEPS   = 32;

  localparam logic signed [4:0] FPH_MIN   = -5'sd8;
  localparam logic signed [4:0] FPH_MAX   = 5'sd8;
  localparam logic signed [4:0] FPH_RESET = -5'sd4;
  localparam logic [2:0]        TERMS_RESET = 3'd6;

  localparam logic [63:0] FIX_ONE    = 64'h0000_0001_0000_0000;
  localparam logic [63:0] TERM_LIMIT = 64'h0800_0000_0000_0000;

  // Nanometre to micrometre scaling, Q16.8 input: 1000 * 256.
  localparam logic [17:0] UM_SCALE = 18'd256000;

  // w * 2^32 / 256000 = w * 2^21 / 125: split w by 125 with an exact
  // reciprocal, then scale the remainder the same way.
  localparam logic [6:0]  UM_DIV     = 7'd125;
  localparam logic [24:0] RCP_Q      = 25'd17179870;   // ceil(2^31 / 125)
  localparam logic [28:0] RCP_R      = 29'd274877907;  // ceil(2^35 / 125)
  localparam int          POS_STAGES = 3;

  // Quotient width of both base paths.
  localparam int          DIV_W       = 56;
  localparam logic [55:0] DIV_NUM_NEG = 56'(UM_SCALE) << 32;

endpackage

>>> design/die_div.sv
module die_div #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 24
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  // Restoring division, one quotient bit per stage. nq shifts numerator
  // bits out at the top and quotient bits in at the bottom.
  logic [DEN_W-1:0] rem [0:NUM_W];
  logic [NUM_W-1:0] nq  [0:NUM_W];
  logic [DEN_W-1:0] dd  [0:NUM_W];

  assign rem[0] = '0;
  assign nq[0]  = num;
  assign dd[0]  = den;

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;

    always_comb begin
      trial = {rem[i], nq[i][NUM_W-1]};
      ge    = trial >= {1'b0, dd[i]};
    end

    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? DEN_W'(trial - {1'b0, dd[i]}) : DEN_W'(trial);
      nq[i+1]  <= {nq[i][NUM_W-2:0], ge};
      dd[i+1]  <= dd[i];
    end
  end

  assign quo = nq[NUM_W];

endmodule

>>> design/dispersion_index_evaluator.sv
// Dispersion index evaluator: refractive index of a glass from a wavelength.
// Command channel: drive wavelength (unsigned Q16.8 nm) and raise start; the
// request is taken at every rising edge where start is high and busy is low.
// busy is high only while rst is asserted, so a new request may be issued in
// every cycle. Configuration goes through wr_en / wr_index / wr_data; write it
// only while no request is in flight.
// Results: done pulses for one cycle with index (unsigned Q4.28, saturated)
// and status (0 ok, 1 negative squared sum, 2 zero wavelength with negative
// power). Each request yields exactly one result, in request order.
// The pipeline is one input register, 56 stages for the base (the divider for
// negative powers, a reciprocal multiply and matching delay for the rest), two
// stages per power-chain step (26 steps for MAX_TERMS = 6), four term/sum
// stages, the 32-stage square root and the output register. One request per
// cycle is sustained.
// Reset is synchronous: it drops every request in flight, clears done and
// restores the register defaults. The receiver cannot stall; a result is
// presented for exactly one cycle.
`include "dispersion_index_evaluator_macros.svh"

module dispersion_index_evaluator import die_pkg::*; #(
  parameter int MAX_TERMS = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [WL_W-1:0]  wavelength,
  input  logic             wr_en,
  input  logic [2:0]       wr_index,
  input  logic [63:0]      wr_data,
  output logic             done,
  output logic [31:0]      index,
  output logic [1:0]       status
);

  // Highest wavelength power: first power up to 2*8, plus two per extra term.
  localparam int NSTEP   = 2 * FPH_SPAN + 2 * (MAX_TERMS - 1);
  localparam int E_W     = $clog2(NSTEP + 1);
  localparam int LATENCY = DIV_W + 2 * NSTEP + SQ_STEPS + 6;

  // ---------------------------------------------------------------- helpers
  function automatic part_t split_mul(input logic [63:0] a, input logic [63:0] b);
    part_t r;
    r[0] = 64'(a[31:0]) * 64'(b[31:0]);
    r[1] = 64'(a[31:0]) * 64'(b[63:32]);
    r[2] = 64'(a[63:32]) * 64'(b[31:0]);
    r[3] = 64'(a[63:32]) * 64'(b[63:32]);
    return r;
  endfunction

  function automatic logic [127:0] join_mul(input part_t pp);
    return {64'b0, pp[0]} + ({64'b0, pp[1]} << 32) + ({64'b0, pp[2]} << 32)
         + ({64'b0, pp[3]} << 64);
  endfunction

  // Q32.32 power step: keep floor(product / 2^32), saturate at all ones.
  function automatic logic [63:0] fix_step(input part_t pp);
    logic [127:0] prod;
    prod = join_mul(pp);
    return (prod[127:96] != '0) ? '1 : prod[95:32];
  endfunction

  // Coefficient times power, down to Q.48 and clipped to 2^59.
  function automatic logic [63:0] term_sat(input part_t pp);
    logic [127:0] prod;
    logic [63:0]  t;
    prod = join_mul(pp);
    t    = (prod[127:88] != '0) ? TERM_LIMIT : prod[87:24];
    return (t > TERM_LIMIT) ? TERM_LIMIT : t;
  endfunction

  // ------------------------------------------------------- configuration
  logic signed [4:0] first_power_half;
  logic [2:0]        term_count;
  logic [63:0]       coeff [NUM_COEFFS];

  always_ff @(posedge clk) begin
    if (rst) begin
      first_power_half <= FPH_RESET;
      term_count       <= TERMS_RESET;
      for (int k = 0; k < NUM_COEFFS; k++) coeff[k] <= '0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_FPH:   first_power_half <= signed'(wr_data[4:0]);
        REG_TERMS: term_count       <= wr_data[2:0];
        REG_C0:    coeff[0]         <= wr_data;
        REG_C1:    coeff[1]         <= wr_data;
        REG_C2:    coeff[2]         <= wr_data;
        REG_C3:    coeff[3]         <= wr_data;
        REG_C4:    coeff[4]         <= wr_data;
        REG_C5:    coeff[5]         <= wr_data;
        default: ;
      endcase
    end
  end

  // Per-term exponent, sign of the power, enable, coefficient sign and magnitude. Every stage reads
  // the registers directly; the user must change them only while idle, which the block does not enforce.
  logic signed [4:0]     fph_c;
  logic [2:0]            terms_c;
  logic signed [5:0]     p0;
  logic [E_W-1:0]        e_pow [MAX_TERMS];
  logic [MAX_TERMS-1:0]  e_neg;
  logic [MAX_TERMS-1:0]  term_on;
  logic [MAX_TERMS-1:0]  c_neg;
  logic [MAX_TERMS-1:0][63:0] mag;
  logic                  wz_block;

  always_comb begin
    logic [5:0] pk;
    if (first_power_half < FPH_MIN)      fph_c = FPH_MIN;
    else if (first_power_half > FPH_MAX) fph_c = FPH_MAX;
    else                                 fph_c = first_power_half;
    terms_c  = (term_count > 3'(MAX_TERMS)) ? 3'(MAX_TERMS) : term_count;
    p0       = {fph_c, 1'b0};
    wz_block = p0[5] && (terms_c != '0);
    for (int k = 0; k < MAX_TERMS; k++) begin
      pk         = 6'(p0) + 6'(2 * k);
      e_neg[k]   = pk[5];
      e_pow[k]   = pk[5] ? E_W'(6'(-pk)) : E_W'(pk);
      term_on[k] = 3'(k) < terms_c;
      c_neg[k]   = coeff[k][63];
      mag[k]     = coeff[k][63] ? 64'(-coeff[k]) : coeff[k];
    end
  end

  // --------------------------------------------------------------- front
  logic            v0;
  logic [WL_W-1:0] w0;

  assign busy = rst;

  always_ff @(posedge clk) begin
    w0 <= wavelength;
    if (rst) v0 <= 1'b0;
    else     v0 <= start && !busy;
  end

  // Base in Q32.32: w / 256000 for non-negative powers, 256000 / w otherwise.
  logic [DIV_W-1:0] quo_p, quo_n;

  // Non-negative powers: quotient of w by 125 from a reciprocal multiply,
  // remainder scaled by 2^21 / 125 the same way, then delayed to line up
  // with the divider.
  logic [48:0]     rq_prod;
  logic [35:0]     rr_prod;
  logic [WL_W-1:0] rw1;
  logic [17:0]     rq1, rq2;
  logic [6:0]      rr2;
  logic [38:0]     pb [POS_STAGES:DIV_W];

  assign rq_prod = 49'(w0) * 49'(RCP_Q);
  assign rr_prod = 36'(rr2) * 36'(RCP_R);

  always_ff @(posedge clk) begin
    rw1            <= w0;
    rq1            <= rq_prod[48:31];
    rq2            <= rq1;
    rr2            <= 7'(rw1 - WL_W'(rq1) * WL_W'(UM_DIV));
    pb[POS_STAGES] <= {rq2, rr_prod[34:14]};
  end

  for (genvar i = POS_STAGES; i < DIV_W; i++) begin : g_pb
    always_ff @(posedge clk) begin
      pb[i+1] <= pb[i];
    end
  end

  assign quo_p = DIV_W'(pb[DIV_W]);

  die_div #(.NUM_W(DIV_W), .DEN_W(WL_W)) u_div_neg (
    .clk (clk),
    .num (DIV_NUM_NEG),
    .den (w0),
    .quo (quo_n)
  );

  // Hold valid and zero-wavelength flag alongside the base paths.
  logic dv [0:DIV_W];
  logic dz [0:DIV_W];

  assign dv[0] = v0;
  assign dz[0] = (w0 == '0);

  for (genvar i = 0; i < DIV_W; i++) begin : g_dly
    always_ff @(posedge clk) begin
      dz[i+1] <= dz[i];
      if (rst) dv[i+1] <= 1'b0;
      else     dv[i+1] <= dv[i];
    end
  end

  // --------------------------------------------------------- power chain
  // Step j forms B^j for both bases over two stages (partials, then sum and
  // saturate); a term whose exponent is j latches its power there.
  logic [63:0] acc_p [0:NSTEP];
  logic [63:0] acc_n [0:NSTEP];
  logic [63:0] bp    [0:NSTEP];
  logic [63:0] bn    [0:NSTEP];
  logic [MAX_TERMS-1:0][63:0] pw [0:NSTEP];
  logic        cv    [0:NSTEP];
  logic        cz    [0:NSTEP];

  part_t       ma_p [1:NSTEP];
  part_t       ma_n [1:NSTEP];
  logic [63:0] abp  [1:NSTEP];
  logic [63:0] abn  [1:NSTEP];
  logic [MAX_TERMS-1:0][63:0] apw [1:NSTEP];
  logic        av   [1:NSTEP];
  logic        az   [1:NSTEP];

  assign acc_p[0] = FIX_ONE;
  assign acc_n[0] = FIX_ONE;
  assign bp[0]    = 64'(quo_p);
  assign bn[0]    = 64'(quo_n);
  assign cv[0]    = dv[DIV_W];
  assign cz[0]    = dz[DIV_W];
  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_pw0
    assign pw[0][k] = FIX_ONE;
  end

  for (genvar j = 1; j <= NSTEP; j++) begin : g_chain
    logic [63:0] np, nn;

    assign np = fix_step(ma_p[j]);
    assign nn = fix_step(ma_n[j]);

    always_ff @(posedge clk) begin
      ma_p[j] <= split_mul(acc_p[j-1], bp[j-1]);
      ma_n[j] <= split_mul(acc_n[j-1], bn[j-1]);
      abp[j]  <= bp[j-1];
      abn[j]  <= bn[j-1];
      apw[j]  <= pw[j-1];
      az[j]   <= cz[j-1];
      if (rst) av[j] <= 1'b0;
      else     av[j] <= cv[j-1];
    end

    always_ff @(posedge clk) begin
      acc_p[j] <= np;
      acc_n[j] <= nn;
      bp[j]    <= abp[j];
      bn[j]    <= abn[j];
      cz[j]    <= az[j];
      for (int k = 0; k < MAX_TERMS; k++) begin
        if (e_pow[k] == E_W'(j)) pw[j][k] <= e_neg[k] ? nn : np;
        else                     pw[j][k] <= apw[j][k];
      end
      if (rst) cv[j] <= 1'b0;
      else     cv[j] <= av[j];
    end
  end

  // ------------------------------------------------------- terms and sum
  part_t       tp [MAX_TERMS];
  logic [63:0] tt [NUM_COEFFS];
  logic [63:0] ps [NUM_COEFFS/2];
  logic [63:0] sum;
  logic        tv1, tv2, tv3, tv4;
  logic        tz1, tz2, tz3, tz4;

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_TERMS; k++) tp[k] <= split_mul(mag[k], pw[NSTEP][k]);
    for (int i = 0; i < NUM_COEFFS / 2; i++) ps[i] <= tt[2*i] + tt[2*i+1];
    sum <= ps[0] + ps[1] + ps[2];
    tz1 <= cz[NSTEP];
    tz2 <= tz1;
    tz3 <= tz2;
    tz4 <= tz3;
    if (rst) begin
      tv1 <= 1'b0;
      tv2 <= 1'b0;
      tv3 <= 1'b0;
      tv4 <= 1'b0;
    end else begin
      tv1 <= cv[NSTEP];
      tv2 <= tv1;
      tv3 <= tv2;
      tv4 <= tv3;
    end
  end

  // Signed Q.48 terms; unused slots hold zero.
  for (genvar k = 0; k < NUM_COEFFS; k++) begin : g_term
    if (k < MAX_TERMS) begin : g_on
      logic [63:0] t;
      assign t = term_sat(tp[k]);
      always_ff @(posedge clk) begin
        if (!term_on[k])   tt[k] <= '0;
        else if (c_neg[k]) tt[k] <= 64'(-t);
        else               tt[k] <= t;
      end
    end else begin : g_off
      always_ff @(posedge clk) begin
        tt[k] <= '0;
      end
    end
  end

  // ---------------------------------------------------------- square root
  logic [63:0] sq_v   [0:SQ_STEPS];
  logic [63:0] sq_r   [0:SQ_STEPS];
  logic        sq_sat [0:SQ_STEPS];
  status_t     sq_st  [0:SQ_STEPS];
  logic        sq_val [0:SQ_STEPS];

  assign sq_v[0]   = {sum[55:0], 8'b0};
  assign sq_r[0]   = '0;
  assign sq_sat[0] = (sum[62:56] != '0);
  assign sq_val[0] = tv4;
  assign sq_st[0]  = (tz4 && wz_block) ? ST_ZERO_WL :
                     sum[63]           ? ST_NEG_SUM : ST_OK;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    localparam logic [63:0] SQ_BIT = 64'(1) << (62 - 2 * i);
    logic [63:0] trial;
    logic        ge;

    always_comb begin
      trial = sq_r[i] + SQ_BIT;
      ge    = sq_v[i] >= trial;
    end

    always_ff @(posedge clk) begin
      sq_v[i+1]   <= ge ? sq_v[i] - trial : sq_v[i];
      sq_r[i+1]   <= ge ? (sq_r[i] >> 1) + SQ_BIT : sq_r[i] >> 1;
      sq_sat[i+1] <= sq_sat[i];
      sq_st[i+1]  <= sq_st[i];
      if (rst) sq_val[i+1] <= 1'b0;
      else     sq_val[i+1] <= sq_val[i];
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    status <= sq_st[SQ_STEPS];
    if (sq_st[SQ_STEPS] != ST_OK) index <= '0;
    else if (sq_sat[SQ_STEPS])    index <= '1;
    else                          index <= sq_r[SQ_STEPS][31:0];
    if (rst) done <= 1'b0;
    else     done <= sq_val[SQ_STEPS];
  end

  // ------------------------------------------------------------ assertions
  `DIE_ASSERT_IMP(a_latency, start && !busy, ##LATENCY done, "request did not complete in time")
  `DIE_ASSERT_IMP(a_err_zero, done && status != ST_OK, (index == '0), "error result with nonzero index")
  `DIE_ASSERT_NEXT(a_sqrt_done, sq_val[SQ_STEPS], done, "finished root not presented")

endmodule
